FILE: hw/rtl/sorted_priority_queue_macros.svh
// assertion macros for the sorted priority queue
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH
`ifndef ASSERT_OFF
`define SPQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPQ_ASSERT(lbl, clk, rst, prop, msg)
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: hw/rtl/spq_pkg.sv
// types and codes shared by the sorted priority queue
package spq_pkg;

   localparam int NAME_LOW_BITS  = 64;
   localparam int NAME_HIGH_BITS = 16;
   localparam int PRIO_PORT_BITS = 16;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_LIST   = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_UNDERFLOW = 2'd1,
      STS_OVERFLOW  = 2'd2,
      STS_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_WALK,
      ST_INS_FINAL,
      ST_RM_FRONT,
      ST_RM_SHIFT,
      ST_LS_DATA,
      ST_RESP
   } state_type;

endpackage

FILE: hw/rtl/sorted_priority_queue.sv
// sorted priority queue top level with its sequencer
//
// Bounded priority queue kept as a sorted list in one entry memory, front at
// slot 0. The req_ channel takes a command (insert, remove, list) with the
// priority and 80-bit name used by insert; the rsp_ channel returns results.
// Insert and remove give one result, list gives one result per entry with
// rsp_last on the final one, or a single empty status.
// Steps per command, with n entries held:
//   insert: one memory read and write per entry walked from
//           the back while the sorted position is found and entries move
//           down, then the new entry is written and the result loaded
//   remove: front read, then each remaining entry moved up one slot
//   list:   one memory read per result
//   full or empty queue: a status result alone; unused command: no result
// The walk uses the single memory port pair. One command is handled at a
// time; req_ready is high in idle.
// A result sits in an output register, so a new command is taken while the
// last result still waits; a state with a result to load holds while that waits.
// Reset (synchronous) empties the queue at once; memory is not cleared.
module sorted_priority_queue import spq_pkg::*; #(
   parameter int QUEUE_DEPTH   = 16,
   parameter int PRIORITY_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_command,
   input  logic [PRIO_PORT_BITS-1:0] req_priority_req,
   input  logic [NAME_LOW_BITS-1:0]  req_name_low,
   input  logic [NAME_HIGH_BITS-1:0] req_name_high,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_status,
   output logic [PRIO_PORT_BITS-1:0] rsp_out_priority,
   output logic [NAME_LOW_BITS-1:0]  rsp_out_name_low,
   output logic [NAME_HIGH_BITS-1:0] rsp_out_name_high,
   output logic                      rsp_last
);

`include "sorted_priority_queue_macros.svh"

   localparam int IDXW = $clog2(QUEUE_DEPTH);
   localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
   localparam int EW   = PRIORITY_BITS + NAME_HIGH_BITS + NAME_LOW_BITS;
   localparam int NHLO = NAME_LOW_BITS;
   localparam int PRLO = NAME_LOW_BITS + NAME_HIGH_BITS;

   state_type                 state_ff, state_in;
   logic [IDXW-1:0]           idx_ff, idx_in;
   logic [CNTW-1:0]           count_ff, count_in;
   logic [PRIORITY_BITS-1:0]  pr_ff, pr_in;
   logic [NAME_LOW_BITS-1:0]  nl_ff, nl_in;
   logic [NAME_HIGH_BITS-1:0] nh_ff, nh_in;
   status_type                status_ff, status_in;

   logic                      rsp_valid_ff;
   status_type                rsp_status_ff;
   logic [PRIO_PORT_BITS-1:0] rsp_prio_ff;
   logic [NAME_LOW_BITS-1:0]  rsp_nl_ff;
   logic [NAME_HIGH_BITS-1:0] rsp_nh_ff;
   logic                      rsp_last_ff;

   logic                      out_load;
   status_type                out_status;
   logic [EW-1:0]             out_entry;
   logic                      out_last;
   logic                      out_free;

   logic                      wr_en;
   logic [IDXW-1:0]           wr_addr;
   logic [EW-1:0]             wr_data;
   logic                      rd_en;
   logic [IDXW-1:0]           rd_addr;
   logic [EW-1:0]             rd_data;

   logic                      req_fire;
   logic [PRIORITY_BITS-1:0]  rd_prio;
   logic [EW-1:0]             new_entry;
   logic [EW-1:0]             req_entry;
   logic                      at_tail;

   spq_mem #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (EW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rd_prio   = rd_data[EW-1:PRLO];
   assign new_entry = {pr_ff, nh_ff, nl_ff};
   assign req_entry = {PRIORITY_BITS'(req_priority_req), req_name_high, req_name_low};
   assign at_tail   = (CNTW'(idx_ff) == count_ff - CNTW'(1));

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      count_in   = count_ff;
      pr_in      = pr_ff;
      nl_in      = nl_ff;
      nh_in      = nh_ff;
      status_in  = status_ff;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = new_entry;
      rd_en      = 1'b0;
      rd_addr    = '0;
      out_load   = 1'b0;
      out_status = STS_OK;
      out_entry  = '0;
      out_last   = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               pr_in = PRIORITY_BITS'(req_priority_req);
               nl_in = req_name_low;
               nh_in = req_name_high;
               case (cmd_type'(req_command))
                  CMD_INSERT: begin
                     if (count_ff == CNTW'(QUEUE_DEPTH)) begin
                        status_in = STS_OVERFLOW;
                        state_in  = ST_RESP;
                     end else if (count_ff == '0) begin
                        wr_en     = 1'b1;
                        wr_addr   = '0;
                        wr_data   = req_entry;
                        count_in  = CNTW'(1);
                        status_in = STS_OK;
                        state_in  = ST_RESP;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = IDXW'(count_ff - CNTW'(1));
                        idx_in   = IDXW'(count_ff - CNTW'(1));
                        state_in = ST_INS_WALK;
                     end
                  end
                  CMD_REMOVE: begin
                     if (count_ff == '0) begin
                        status_in = STS_UNDERFLOW;
                        state_in  = ST_RESP;
                     end else begin
                        rd_en    = 1'b1;
                        idx_in   = '0;
                        state_in = ST_RM_FRONT;
                     end
                  end
                  CMD_LIST: begin
                     if (count_ff == '0) begin
                        status_in = STS_EMPTY;
                        state_in  = ST_RESP;
                     end else begin
                        rd_en    = 1'b1;
                        idx_in   = '0;
                        state_in = ST_LS_DATA;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         // walk from the back: larger entries move down one slot
         ST_INS_WALK: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff + IDXW'(1);
            if (rd_prio > pr_ff) begin
               wr_data = rd_data;
               if (idx_ff == '0) begin
                  state_in = ST_INS_FINAL;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_ff - IDXW'(1);
                  idx_in  = idx_ff - IDXW'(1);
               end
            end else begin
               wr_data   = new_entry;
               count_in  = count_ff + CNTW'(1);
               status_in = STS_OK;
               state_in  = ST_RESP;
            end
         end
         ST_INS_FINAL: begin
            wr_en     = 1'b1;
            wr_addr   = '0;
            wr_data   = new_entry;
            count_in  = count_ff + CNTW'(1);
            status_in = STS_OK;
            state_in  = ST_RESP;
         end
         ST_RM_FRONT: begin
            if (out_free) begin
               out_load  = 1'b1;
               out_entry = rd_data;
               if (count_ff == CNTW'(1)) begin
                  count_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = IDXW'(1);
                  idx_in   = IDXW'(1);
                  state_in = ST_RM_SHIFT;
               end
            end
         end
         // move each remaining entry up one slot
         ST_RM_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff - IDXW'(1);
            wr_data = rd_data;
            if (at_tail) begin
               count_in = count_ff - CNTW'(1);
               state_in = ST_IDLE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_ff + IDXW'(1);
               idx_in  = idx_ff + IDXW'(1);
            end
         end
         ST_LS_DATA: begin
            if (out_free) begin
               out_load  = 1'b1;
               out_entry = rd_data;
               out_last  = at_tail;
               if (at_tail) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_ff + IDXW'(1);
                  idx_in  = idx_ff + IDXW'(1);
               end
            end
         end
         ST_RESP: begin
            if (out_free) begin
               out_load   = 1'b1;
               out_status = status_ff;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      pr_ff     <= pr_in;
      nl_ff     <= nl_in;
      nh_ff     <= nh_in;
      status_ff <= status_in;
      if (out_load) begin
         rsp_status_ff <= out_status;
         rsp_prio_ff   <= PRIO_PORT_BITS'(out_entry[EW-1:PRLO]);
         rsp_nh_ff     <= out_entry[PRLO-1:NHLO];
         rsp_nl_ff     <= out_entry[NHLO-1:0];
         rsp_last_ff   <= out_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_out_priority  = rsp_prio_ff;
   assign rsp_out_name_low  = rsp_nl_ff;
   assign rsp_out_name_high = rsp_nh_ff;
   assign rsp_last          = rsp_last_ff;

   `SPQ_ASSERT(a_count_bound, clock, reset, count_ff <= CNTW'(QUEUE_DEPTH), "entry count above depth")
   `SPQ_ASSERT(a_not_last_only_list, clock, reset, rsp_valid_ff && !rsp_last_ff |-> state_ff == ST_LS_DATA, "non-final result outside a list")
   `SPQ_ASSERT(a_full_insert, clock, reset, req_fire && req_command == CMD_INSERT && count_ff == CNTW'(QUEUE_DEPTH) |=> state_ff == ST_RESP && status_ff == STS_OVERFLOW && $stable(count_ff), "insert into full queue not flagged")

endmodule

FILE: hw/rtl/spq_mem.sv
// entry memory: one write port, one read port, registered read data
module spq_mem import spq_pkg::*; #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 96
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
